FILE: rtl/wvpd_pkg.sv
// ----------------------------------------------------------------------------
// wvpd_pkg
// Shared types, codes and fixed-point helpers of the waypoint velocity step.
// ----------------------------------------------------------------------------
package wvpd_pkg;

    localparam int DATA_W = 32;
    localparam int CFG_IDX_W = 3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_X     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_Y     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_Z     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TRACK_GAIN   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ATTRACT_GAIN = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SPEED_LIMIT  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_TICK_PERIOD  = 3'd6;

    // contact modes
    localparam logic [2:0] MODE_DEV_C    = 3'd0;
    localparam logic [2:0] MODE_DEV_O    = 3'd1;
    localparam logic [2:0] MODE_OPPOSITE = 3'd2;
    localparam logic [2:0] MODE_CONCORDE = 3'd3;

    // blend factors, Q16
    localparam logic [17:0] FAC_1P5 = 18'd98304;
    localparam logic [17:0] FAC_3P0 = 18'd196608;
    localparam logic [17:0] FAC_1P0 = 18'd65536;
    localparam logic [17:0] FAC_0P8 = 18'd52429;
    localparam logic [17:0] FAC_ZERO = 18'd0;

    localparam logic [32:0] ARRIVE_R  = 33'd2621;
    localparam logic [24:0] ARRIVE_R2 = 25'd6869641;

    localparam logic [31:0] RST_GAIN = 32'd65536;
    localparam logic [31:0] RST_TICK = 32'd66;

    typedef enum logic [4:0] {
        ST_IDLE, ST_TRK, ST_ATT, ST_BT, ST_BA, ST_RND,
        ST_SQ, ST_SQA, ST_LIM, ST_CMP, ST_SQRT,
        ST_MULS, ST_DLD, ST_DIV, ST_DST,
        ST_DSP, ST_DSA, ST_FIN, ST_OUT
    } state_t;

    typedef struct packed {
        logic [17:0] fa;
        logic [17:0] ft;
    } factors_t;

    function automatic factors_t mode_factors(input logic [2:0] mode, input logic valid);
        factors_t f;
        f.fa = FAC_ZERO;
        f.ft = FAC_0P8;
        if (mode == MODE_DEV_C && valid) begin
            f.fa = FAC_1P5;
            f.ft = FAC_1P5;
        end else if (mode == MODE_DEV_O && valid) begin
            f.fa = FAC_3P0;
            f.ft = FAC_ZERO;
        end else if (mode == MODE_OPPOSITE) begin
            f.ft = FAC_ZERO;
        end else if (mode == MODE_CONCORDE) begin
            f.ft = FAC_1P0;
        end
        return f;
    endfunction

    function automatic logic signed [31:0] sat_mag(input logic neg, input logic [66:0] r);
        logic signed [31:0] v;
        if (neg) begin
            if (r >= 67'h80000000) v = 32'sh80000000;
            else v = -$signed(r[31:0]);
        end else begin
            if (r > 67'h7fffffff) v = 32'sh7fffffff;
            else v = $signed(r[31:0]);
        end
        return v;
    endfunction

    // magnitude of a q.32 product back to q.16, half away from zero
    function automatic logic signed [31:0] q16_round(input logic neg, input logic [65:0] mag);
        logic [66:0] s;
        s = {1'b0, mag} + 67'd32768;
        return sat_mag(neg, {16'd0, s[66:16]});
    endfunction

    function automatic logic signed [31:0] sat_add(input logic signed [31:0] a,
                                                   input logic signed [31:0] b);
        logic signed [32:0] s;
        s = {a[31], a} + {b[31], b};
        if (s > 33'sh07fffffff) return 32'sh7fffffff;
        if (s < -33'sh080000000) return 32'sh80000000;
        return s[31:0];
    endfunction

    function automatic logic [31:0] abs32(input logic signed [31:0] v);
        return v[31] ? 32'(-v) : 32'(v);
    endfunction

    function automatic logic [32:0] abs33(input logic signed [32:0] v);
        return v[32] ? 33'(-v) : 33'(v);
    endfunction

endpackage

FILE: rtl/waypoint_velocity_pd_step.sv
// ----------------------------------------------------------------------------
// waypoint_velocity_pd_step
// Per-tick blended tracking/attraction velocity with length limit,
// displacement accumulation and arrival latch.
// ----------------------------------------------------------------------------
//  channel | dir | handshake          | word
//  s_      | in  | s_valid / s_ready  | position, mode, attraction point
//  m_      | out | m_valid / m_ready  | velocity, displacement, arrived
//  cfg_    | in  | cfg_valid/cfg_ready| register index and data
//
//  one shared 33x32 multiplier, a 1-bit/cycle square root and divider.
//  when the speed limit acts, a word adds 32 root steps and, per axis,
//  a multiply, a divider load, 63 divide steps and a store. after arrival
//  a word skips the computation and goes straight to output. reset clears
//  control state and the displacement; a stalled result holds in the
//  output register and the next word waits only once that is full.
module waypoint_velocity_pd_step
    import wvpd_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic signed [31:0]   s_pos_x,
    input  logic signed [31:0]   s_pos_y,
    input  logic signed [31:0]   s_pos_z,
    input  logic [2:0]           s_contact_mode,
    input  logic                 s_attract_valid,
    input  logic signed [31:0]   s_attract_x,
    input  logic signed [31:0]   s_attract_y,
    input  logic signed [31:0]   s_attract_z,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic signed [31:0]   m_vel_x,
    output logic signed [31:0]   m_vel_y,
    output logic signed [31:0]   m_vel_z,
    output logic signed [31:0]   m_disp_x,
    output logic signed [31:0]   m_disp_y,
    output logic signed [31:0]   m_disp_z,
    output logic                 m_arrived,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DATA_W-1:0]    cfg_data
);

    state_t state_reg, state_next;

    logic signed [31:0] tgt_reg [3];
    logic [31:0] track_gain_reg, attract_gain_reg, speed_limit_reg, tick_period_reg;

    logic signed [31:0] pos_reg [3];
    logic signed [31:0] att_reg [3];
    factors_t fac_reg;
    logic [1:0] ax_reg;

    logic signed [31:0] vt_reg, va_reg;
    logic signed [51:0] acc_reg;
    logic signed [31:0] vel_reg [3];
    logic signed [31:0] disp_reg [3];
    logic finished_reg;
    logic [63:0] sum_reg;

    logic [63:0] sq_x_reg, sq_r_reg;
    logic [4:0]  sq_k_reg;
    logic [32:0] div_n_reg, div_rem_reg;
    logic [62:0] div_q_reg;
    logic [5:0]  div_cnt_reg;

    logic [32:0] mul_a;
    logic [31:0] mul_b;
    logic [64:0] prod_reg;

    logic m_valid_reg;

    function automatic logic [51:0] abs52(input logic signed [51:0] v);
        return v[51] ? 52'(-v) : 52'(v);
    endfunction

    logic s_fire;
    assign s_ready   = (state_reg == ST_IDLE);
    assign s_fire    = s_valid && s_ready;
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;

    // per-axis errors
    logic signed [32:0] e_t, e_a;
    assign e_t = {tgt_reg[ax_reg][31], tgt_reg[ax_reg]} - {pos_reg[ax_reg][31], pos_reg[ax_reg]};
    assign e_a = {att_reg[ax_reg][31], att_reg[ax_reg]} - {pos_reg[ax_reg][31], pos_reg[ax_reg]};

    logic [31:0] vel_mag;
    logic        vel_neg;
    assign vel_mag = abs32(vel_reg[ax_reg]);
    assign vel_neg = vel_reg[ax_reg][31];

    // shared multiplier operand select
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_TRK: begin
                mul_a = abs33(e_t);
                mul_b = track_gain_reg;
            end
            ST_ATT: begin
                mul_a = abs33(e_a);
                mul_b = attract_gain_reg;
            end
            ST_BT: begin
                mul_a = {1'b0, abs32(vt_reg)};
                mul_b = {14'd0, fac_reg.ft};
            end
            ST_BA: begin
                mul_a = {1'b0, abs32(va_reg)};
                mul_b = {14'd0, fac_reg.fa};
            end
            ST_SQ: begin
                mul_a = {1'b0, vel_mag};
                mul_b = vel_mag;
            end
            ST_LIM: begin
                mul_a = {1'b0, speed_limit_reg};
                mul_b = speed_limit_reg;
            end
            ST_MULS: begin
                mul_a = {1'b0, vel_mag};
                mul_b = speed_limit_reg;
            end
            ST_DSP: begin
                mul_a = {1'b0, vel_mag};
                mul_b = tick_period_reg;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // blend term from the last product, signed by its operand
    logic signed [51:0] term;
    logic               term_neg;
    logic signed [51:0] acc_sum;
    assign term_neg = (state_reg == ST_RND) ? va_reg[31] : vt_reg[31];
    assign term     = term_neg ? -$signed({1'b0, prod_reg[50:0]}) : $signed({1'b0, prod_reg[50:0]});
    assign acc_sum  = acc_reg + term;

    // root step
    logic [63:0] sq_bit, sq_t;
    assign sq_bit = 64'd1 << {sq_k_reg, 1'b0};
    assign sq_t   = sq_r_reg + sq_bit;

    // divide step
    logic [33:0] div_sh;
    logic        div_ge;
    assign div_sh = {div_rem_reg, div_q_reg[62]};
    assign div_ge = div_sh >= {1'b0, div_n_reg};

    // arrival test
    logic [32:0] dxm, dym;
    logic [24:0] d2;
    logic        hit;
    assign dxm = abs33({tgt_reg[0][31], tgt_reg[0]} - {pos_reg[0][31], pos_reg[0]});
    assign dym = abs33({tgt_reg[1][31], tgt_reg[1]} - {pos_reg[1][31], pos_reg[1]});
    assign d2  = ({13'd0, dxm[11:0]} * {13'd0, dxm[11:0]}) +
                 ({13'd0, dym[11:0]} * {13'd0, dym[11:0]});
    assign hit = (dxm <= ARRIVE_R) && (dym <= ARRIVE_R) && (d2 <= ARRIVE_R2);

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (s_fire) state_next = finished_reg ? ST_OUT : ST_TRK;
            ST_TRK:  state_next = ST_ATT;
            ST_ATT:  state_next = ST_BT;
            ST_BT:   state_next = ST_BA;
            ST_BA:   state_next = ST_RND;
            ST_RND:  state_next = (ax_reg == 2'd2) ? ST_SQ : ST_TRK;
            ST_SQ:   state_next = ST_SQA;
            ST_SQA:  state_next = (ax_reg == 2'd2) ? ST_LIM : ST_SQ;
            ST_LIM:  state_next = ST_CMP;
            ST_CMP:  state_next = (sum_reg > prod_reg[63:0]) ? ST_SQRT : ST_DSP;
            ST_SQRT: if (sq_k_reg == 5'd0) state_next = ST_MULS;
            ST_MULS: state_next = ST_DLD;
            ST_DLD:  state_next = ST_DIV;
            ST_DIV:  if (div_cnt_reg == 6'd62) state_next = ST_DST;
            ST_DST:  state_next = (ax_reg == 2'd2) ? ST_DSP : ST_MULS;
            ST_DSP:  state_next = ST_DSA;
            ST_DSA:  state_next = (ax_reg == 2'd2) ? ST_FIN : ST_DSP;
            ST_FIN:  state_next = ST_OUT;
            ST_OUT:  if (!m_valid_reg || m_ready) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 3; i++) begin
                tgt_reg[i]  <= '0;
                disp_reg[i] <= '0;
            end
            track_gain_reg   <= RST_GAIN;
            attract_gain_reg <= RST_GAIN;
            speed_limit_reg  <= RST_GAIN;
            tick_period_reg  <= RST_TICK;
            finished_reg     <= 1'b0;
            m_valid_reg      <= 1'b0;
            ax_reg           <= '0;
        end else begin
            if (cfg_valid) begin
                case (cfg_index)
                    REG_TARGET_X:     tgt_reg[0]       <= cfg_data;
                    REG_TARGET_Y:     tgt_reg[1]       <= cfg_data;
                    REG_TARGET_Z:     tgt_reg[2]       <= cfg_data;
                    REG_TRACK_GAIN:   track_gain_reg   <= cfg_data;
                    REG_ATTRACT_GAIN: attract_gain_reg <= cfg_data;
                    REG_SPEED_LIMIT:  speed_limit_reg  <= cfg_data;
                    REG_TICK_PERIOD:  tick_period_reg  <= cfg_data;
                    default: ;
                endcase
            end
            if (state_reg == ST_OUT && (!m_valid_reg || m_ready)) begin
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE: begin
                    ax_reg <= '0;
                    if (s_fire) begin
                        pos_reg[0] <= s_pos_x;
                        pos_reg[1] <= s_pos_y;
                        pos_reg[2] <= s_pos_z;
                        att_reg[0] <= s_attract_x;
                        att_reg[1] <= s_attract_y;
                        att_reg[2] <= s_attract_z;
                        fac_reg    <= mode_factors(s_contact_mode, s_attract_valid);
                        sum_reg    <= '0;
                        for (int i = 0; i < 3; i++) vel_reg[i] <= '0;
                    end
                end
                ST_ATT: vt_reg <= q16_round(e_t[32], {1'b0, prod_reg});
                ST_BT:  va_reg <= q16_round(e_a[32], {1'b0, prod_reg});
                ST_BA:  acc_reg <= term;
                ST_RND: begin
                    vel_reg[ax_reg] <= q16_round(acc_sum[51], 66'(abs52(acc_sum)));
                    ax_reg <= (ax_reg == 2'd2) ? 2'd0 : ax_reg + 2'd1;
                end
                ST_SQA: begin
                    sum_reg <= sum_reg + prod_reg[63:0];
                    ax_reg  <= (ax_reg == 2'd2) ? 2'd0 : ax_reg + 2'd1;
                end
                ST_CMP: begin
                    sq_x_reg <= sum_reg;
                    sq_r_reg <= '0;
                    sq_k_reg <= 5'd31;
                end
                ST_SQRT: begin
                    if (sq_x_reg >= sq_t) begin
                        sq_x_reg <= sq_x_reg - sq_t;
                        sq_r_reg <= (sq_r_reg >> 1) + sq_bit;
                    end else begin
                        sq_r_reg <= sq_r_reg >> 1;
                    end
                    sq_k_reg <= sq_k_reg - 5'd1;
                end
                ST_MULS: begin
                    if (sq_k_reg == 5'd31) div_n_reg <= sq_r_reg[32:0];
                end
                ST_DLD: begin
                    div_q_reg   <= prod_reg[62:0];
                    div_rem_reg <= '0;
                    div_cnt_reg <= '0;
                end
                ST_DIV: begin
                    div_rem_reg <= div_ge ? 33'(div_sh - {1'b0, div_n_reg}) : div_sh[32:0];
                    div_q_reg   <= {div_q_reg[61:0], div_ge};
                    div_cnt_reg <= div_cnt_reg + 6'd1;
                end
                ST_DST: begin
                    vel_reg[ax_reg] <= sat_mag(vel_neg, {4'd0, div_q_reg});
                    ax_reg <= (ax_reg == 2'd2) ? 2'd0 : ax_reg + 2'd1;
                end
                ST_DSA: begin
                    disp_reg[ax_reg] <= sat_add(disp_reg[ax_reg],
                                                q16_round(vel_neg, {1'b0, prod_reg}));
                    ax_reg <= (ax_reg == 2'd2) ? 2'd0 : ax_reg + 2'd1;
                end
                ST_FIN: begin
                    if (hit) finished_reg <= 1'b1;
                end
                ST_OUT: begin
                    if (!m_valid_reg || m_ready) begin
                        m_vel_x     <= vel_reg[0];
                        m_vel_y     <= vel_reg[1];
                        m_vel_z     <= vel_reg[2];
                        m_disp_x    <= disp_reg[0];
                        m_disp_y    <= disp_reg[1];
                        m_disp_z    <= disp_reg[2];
                        m_arrived   <= finished_reg;
                    end
                end
                default: ;
            endcase
        end
    end

    // sqrt ends with k wrapped to 31; divisor is reloaded from the root on every axis
    always_ff @(posedge aclk) begin
        prod_reg <= mul_a * mul_b;
    end

endmodule

FILE: rtl/wvpd_checker.sv
// ----------------------------------------------------------------------------
// wvpd_checker
// Port-level checks of the waypoint velocity step, bound to the top level.
// ----------------------------------------------------------------------------
module wvpd_checker
    import wvpd_pkg::*;
(
    input logic               aclk,
    input logic               aresetn,
    input logic               s_valid,
    input logic               s_ready,
    input logic               m_valid,
    input logic               m_ready,
    input logic signed [31:0] m_vel_x,
    input logic signed [31:0] m_disp_x,
    input logic               cfg_ready
);

    // a stalled word holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_vel_x) && $stable(m_disp_x))
        else $error("stalled result changed");

    // one word at a time
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("accepted while busy");

    // a result is not raised directly on acceptance: m_valid is set only from ST_OUT
    a_lat: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !$rose(m_valid))
        else $error("result too early");

    a_cfg: assert property (@(posedge aclk) disable iff (!aresetn) cfg_ready)
        else $error("config port not ready");

endmodule

bind waypoint_velocity_pd_step wvpd_checker u_wvpd_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .s_valid   (s_valid),
    .s_ready   (s_ready),
    .m_valid   (m_valid),
    .m_ready   (m_ready),
    .m_vel_x   (m_vel_x),
    .m_disp_x  (m_disp_x),
    .cfg_ready (cfg_ready)
);
